FILE: src/whpp_pkg.sv
// shared types, constants and helpers for the wav header parser
`default_nettype none

package whpp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int SLOT_W   = 13;
    localparam int BPF_W    = SLOT_W + HALF_W;
    localparam int PEAK_W   = 15;
    localparam int POS_W    = 6;
    localparam int TDATA_W  = 120;
    localparam int TUSER_W  = 2;
    localparam int PADDR_W  = 3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_HEADER = 2'd0;
    localparam t_kind KIND_PEAK   = 2'd1;
    localparam t_kind KIND_ERROR  = 2'd2;

    typedef logic [3:0] t_err;
    localparam t_err ERR_NONE       = 4'd0;
    localparam t_err ERR_RIFF       = 4'd1;
    localparam t_err ERR_WAVE       = 4'd2;
    localparam t_err ERR_FMT        = 4'd3;
    localparam t_err ERR_FMT_SIZE   = 4'd4;
    localparam t_err ERR_NON_PCM    = 4'd5;
    localparam t_err ERR_DATA_TAG   = 4'd6;
    localparam t_err ERR_ZERO_FRAME = 4'd7;
    localparam t_err ERR_TRUNCATED  = 4'd8;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PEAK = 2'd2;

    localparam logic [PADDR_W-1:0] REG_MODE_ADDR = 3'd0;

    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_SIZE = 32'd16;
    localparam logic [HALF_W-1:0] FMT_PCM  = 16'd1;

    typedef logic [POS_W-1:0] t_pos;
    localparam t_pos POS_RIFF     = 6'd3;
    localparam t_pos POS_WAVE     = 6'd11;
    localparam t_pos POS_FMT      = 6'd15;
    localparam t_pos POS_FMT_SIZE = 6'd19;
    localparam t_pos POS_FORMAT   = 6'd21;
    localparam t_pos POS_CHANNELS = 6'd23;
    localparam t_pos POS_RATE     = 6'd27;
    localparam t_pos POS_WIDTH    = 6'd35;
    localparam t_pos POS_DATA     = 6'd39;
    localparam t_pos POS_LAST     = 6'd43;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        t_err                code;
        logic [WORD_W-1:0]   rate;
        logic [HALF_W-1:0]   channels;
        logic [HALF_W-1:0]   width;
        logic [WORD_W-1:0]   frames;
        logic [PEAK_W-1:0]   peak;
    } t_res;

    typedef struct packed {
        logic accept;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic [1:0] res_count;
        logic       need_div;
        logic       div_done;
    } t_status;

    function automatic logic [PEAK_W-1:0] consider(input logic [PEAK_W-1:0] peak,
                                                   input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] mag;
        mag = v[HALF_W-1] ? (~v + 16'd1) : v;
        if (v == 16'h8000) begin
            return peak;
        end else if (mag[PEAK_W-1:0] > peak) begin
            return mag[PEAK_W-1:0];
        end else begin
            return peak;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/whpp_div.sv
// restoring divider for the frame count, one quotient bit per cycle
`default_nettype none

module whpp_div
    import whpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [BPF_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [WORD_W-1:0]   r_quo, n_quo;
    logic [BPF_W-1:0]    r_rem, n_rem;
    logic [BPF_W-1:0]    r_div, n_div;

    logic [BPF_W:0]      rem_sh;
    logic [BPF_W:0]      diff;
    logic                ge;
    logic [WORD_W-1:0]   quo_step;

    always_comb begin
        rem_sh   = {r_rem, r_quo[WORD_W-1]};
        diff     = rem_sh - {1'b0, r_div};
        ge       = rem_sh >= {1'b0, r_div};
        quo_step = {r_quo[WORD_W-2:0], ge};
        o_done     = r_busy && (r_cnt == CNT_LAST);
        o_quotient = quo_step;

        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = quo_step;
            n_rem = ge ? diff[BPF_W-1:0] : rem_sh[BPF_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

endmodule

`default_nettype wire

FILE: src/whpp_dpath.sv
// parser datapath: header fields, data scan, result registers and divider
`default_nettype none

module whpp_dpath
    import whpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire t_mode             i_mode,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    output t_status                o_status,
    output t_res                   o_result
);

    t_phase              r_phase, n_phase;
    t_pos                r_pos, n_pos;
    logic [WORD_W-1:0]   r_fs, n_fs;
    logic [HALF_W-1:0]   r_ch, n_ch;
    logic [WORD_W-1:0]   r_rate, n_rate;
    logic [HALF_W-1:0]   r_width, n_width;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [SLOT_W-1:0]   r_off, n_off;
    logic [BYTE_W-1:0]   r_low, n_low;
    logic [PEAK_W-1:0]   r_peak, n_peak;
    logic [BPF_W-1:0]    r_bpf;
    t_res                r_first, r_second;

    t_err                err;
    logic                hdr, peak_zero, peak_out, trunc;
    logic [SLOT_W-1:0]   slot, off_inc;
    logic [WORD_W-1:0]   rem_dec;
    t_res                res_a, res_b, res_hdr, res_err, res_peak, res_trunc;
    logic [1:0]          count;
    logic                div_done;
    logic [WORD_W-1:0]   quotient;

    whpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept && hdr),
        .i_dividend ({i_byte, r_fs[WORD_W-1:BYTE_W]}),
        .i_divisor  (r_bpf),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_fs    = r_fs;
        n_ch    = r_ch;
        n_rate  = r_rate;
        n_width = r_width;
        n_rem   = r_rem;
        n_off   = r_off;
        n_low   = r_low;
        n_peak  = r_peak;
        err       = ERR_NONE;
        hdr       = 1'b0;
        peak_zero = 1'b0;
        peak_out  = 1'b0;
        slot      = r_width[HALF_W-1:3];
        off_inc   = r_off + SLOT_W'(1);
        rem_dec   = r_rem;
        if (slot == '0) begin
            slot = SLOT_W'(1);
        end

        unique case (r_phase)
            PH_HEADER: begin
                n_fs = {i_byte, r_fs[WORD_W-1:BYTE_W]};
                unique case (r_pos)
                    POS_RIFF:     if (n_fs != TAG_RIFF) err = ERR_RIFF;
                    POS_WAVE:     if (n_fs != TAG_WAVE) err = ERR_WAVE;
                    POS_FMT:      if (n_fs != TAG_FMT) err = ERR_FMT;
                    POS_FMT_SIZE: if (n_fs != FMT_SIZE) err = ERR_FMT_SIZE;
                    POS_FORMAT:   if (n_fs[WORD_W-1:HALF_W] != FMT_PCM) err = ERR_NON_PCM;
                    POS_CHANNELS: n_ch = n_fs[WORD_W-1:HALF_W];
                    POS_RATE:     n_rate = n_fs;
                    POS_WIDTH:    n_width = n_fs[WORD_W-1:HALF_W];
                    POS_DATA:     if (n_fs != TAG_DATA) err = ERR_DATA_TAG;
                    POS_LAST: begin
                        if (r_bpf == '0) begin
                            err = ERR_ZERO_FRAME;
                        end else begin
                            hdr     = 1'b1;
                            n_phase = PH_SKIP;
                            if (i_mode == MODE_PEAK) begin
                                n_peak = '0;
                                if (n_fs == '0) begin
                                    peak_zero = 1'b1;
                                end else begin
                                    n_phase = PH_DATA;
                                    n_rem   = n_fs;
                                    n_off   = '0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                if (err != ERR_NONE) begin
                    n_phase = PH_SKIP;
                end else if (r_pos < POS_LAST) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            PH_DATA: begin
                if (slot == SLOT_W'(1)) begin
                    if (r_off != '0) begin
                        n_peak = consider(n_peak, {i_byte, r_low});
                    end
                    n_low = i_byte;
                    n_off = SLOT_W'(1);
                    if (r_rem == WORD_W'(1)) begin
                        n_peak = consider(n_peak, {8'h00, i_byte});
                    end
                end else begin
                    if (r_off == '0) begin
                        n_low = i_byte;
                    end else if (r_off == SLOT_W'(1) &&
                                 r_rem >= WORD_W'(slot - SLOT_W'(1))) begin
                        n_peak = consider(n_peak, {i_byte, r_low});
                    end
                    n_off = (off_inc >= slot) ? '0 : off_inc;
                end
                if (r_rem != '0) begin
                    rem_dec = r_rem - WORD_W'(1);
                end
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    peak_out = 1'b1;
                    n_phase  = PH_SKIP;
                end
            end
            PH_SKIP: ;
            default: ;
        endcase

        trunc = i_last && (n_phase != PH_SKIP);

        res_hdr   = '{kind: KIND_HEADER, code: ERR_NONE, rate: r_rate, channels: r_ch,
                      width: r_width, frames: '0, peak: '0};
        res_err   = '{kind: KIND_ERROR, code: err, rate: '0, channels: '0,
                      width: '0, frames: '0, peak: '0};
        res_peak  = '{kind: KIND_PEAK, code: ERR_NONE, rate: '0, channels: '0,
                      width: '0, frames: '0, peak: (peak_zero ? '0 : n_peak)};
        res_trunc = '{kind: KIND_ERROR, code: ERR_TRUNCATED, rate: '0, channels: '0,
                      width: '0, frames: '0, peak: '0};

        res_a = res_trunc;
        res_b = res_trunc;
        count = 2'd0;
        if (hdr) begin
            res_a = res_hdr;
            if (peak_zero) begin
                res_b = res_peak;
                count = 2'd2;
            end else if (trunc) begin
                count = 2'd2;
            end else begin
                count = 2'd1;
            end
        end else if (err != ERR_NONE) begin
            res_a = res_err;
            count = 2'd1;
        end else if (peak_out) begin
            res_a = res_peak;
            count = 2'd1;
        end else if (trunc) begin
            count = 2'd1;
        end

        if (i_last) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_fs    = '0;
            n_ch    = '0;
            n_rate  = '0;
            n_width = '0;
            n_rem   = '0;
            n_off   = '0;
            n_low   = '0;
            n_peak  = '0;
        end

        o_status = '{res_count: count, need_div: hdr, div_done: div_done};
        o_result = r_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_fs    <= '0;
            r_ch    <= '0;
            r_rate  <= '0;
            r_width <= '0;
            r_rem   <= '0;
            r_off   <= '0;
            r_low   <= '0;
            r_peak  <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_fs    <= n_fs;
            r_ch    <= n_ch;
            r_rate  <= n_rate;
            r_width <= n_width;
            r_rem   <= n_rem;
            r_off   <= n_off;
            r_low   <= n_low;
            r_peak  <= n_peak;
        end
    end

    // bytes per frame, settled well before the last header byte
    always_ff @(posedge i_clk) begin
        r_bpf <= BPF_W'(r_width[HALF_W-1:3]) * BPF_W'(r_ch);
        if (i_cmd.accept && count != 2'd0) begin
            r_first  <= res_a;
            r_second <= res_b;
        end else if (i_cmd.pop) begin
            r_first <= r_second;
        end else if (div_done) begin
            r_first.frames <= quotient;
        end
    end

endmodule

`default_nettype wire

FILE: src/whpp_ctrl.sv
// flow controller: input stall, division wait and result hand-off
`default_nettype none

module whpp_ctrl
    import whpp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        CS_RUN = 2'b01,
        CS_DIV = 2'b10
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        r_second, n_second;
    logic        out_take;

    always_comb begin
        o_in_ready  = (r_state == CS_RUN) && !r_second && (!r_out_valid || i_out_ready);
        o_out_valid = r_out_valid;
        out_take    = r_out_valid && i_out_ready;
        o_cmd.accept = i_in_valid && o_in_ready;
        o_cmd.pop    = out_take && r_second;

        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_second    = r_second;
        unique case (r_state)
            CS_RUN: begin
                if (o_cmd.accept) begin
                    n_second = (i_status.res_count == 2'd2);
                    if (i_status.need_div) begin
                        n_state     = CS_DIV;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid = (i_status.res_count != 2'd0);
                    end
                end else if (out_take) begin
                    if (r_second) begin
                        n_second = 1'b0;
                    end else begin
                        n_out_valid = 1'b0;
                    end
                end
            end
            CS_DIV: begin
                if (i_status.div_done) begin
                    n_state     = CS_RUN;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = CS_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_RUN;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

endmodule

`default_nettype wire

FILE: src/wav_header_parse_peak.sv
// top level: wav header parser with peak scan, stream ports and register port
//
// Takes a WAV file one byte per word on the input stream (tlast on the final
// byte) and checks the 44-byte canonical header. Header and data bytes are
// taken at one per cycle unless the input is stalled. After the last byte of
// a valid header the input stalls while the frame-count divider produces one
// quotient bit per cycle; the header result appears when it finishes. A byte
// that yields two results holds the input until the second result has been
// taken. The output word sits in a register, and a new byte is accepted in
// the same cycle as the pending result is taken. report_mode lives at address
// 0 of the register port; write it only while the block is idle.
`default_nettype none

module wav_header_parse_peak
    import whpp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // in_byte
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // error_code, sample_rate, channel_count, sample_width_bits,
    // frame_count, peak_value, zero fill
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [TUSER_W-1:0]      m_axis_tuser,   // result_kind
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]       prdata,
    output logic                    pready
);

    t_mode   r_mode;
    t_cmd    cmd;
    t_status status;
    t_res    result;
    logic    reg_hit;

    assign reg_hit = (paddr[PADDR_W-1:2] == REG_MODE_ADDR[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(WORD_W-2){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_mode <= pwdata[1:0];
        end
    end

    whpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    whpp_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_mode   (r_mode),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_status (status),
        .o_result (result)
    );

    assign m_axis_tdata = {5'b0, result.peak, result.frames, result.width,
                           result.channels, result.rate, result.code};
    assign m_axis_tuser = result.kind;

    a_done_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_done |-> !s_axis_tready)
        else $error("divider finished while input was open");

    a_div_hides_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && status.need_div) |=> !m_axis_tvalid)
        else $error("result shown before frame count was ready");

    a_pop_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> (m_axis_tvalid && m_axis_tready && !s_axis_tready))
        else $error("second result moved without a take");

    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && status.res_count == 2'd0 && !status.need_div) |=> !m_axis_tvalid)
        else $error("word shown for a byte with no result");

endmodule

`default_nettype wire
